// File: rtl/core/qrot_pkg.sv
package qrot_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 16;

  // angle reduction: u = floor((h * 2^22 + 22) / 45) via h = 45q + r
  localparam int ANG_DIV    = 45;
  localparam int ANG_RECIP  = 23302;  // ceil(2^20 / 45)
  localparam int ANG_RSH    = 20;
  localparam int FRAC_STEP  = 93206;  // floor(2^22 / 45)
  localparam int FRAC_SCALE = 34;     // 2^22 mod 45
  localparam int FRAC_BIAS  = 22;
  localparam int RES_RECIP  = 1457;   // ceil(2^16 / 45)
  localparam int RES_RSH    = 16;
  localparam int TURN_UNITS = 23040;

  localparam int CW          = 34;
  localparam int CORDIC_GAIN = 652032874;
  localparam int CRD_SH      = 30 - FRAC_BITS;

  localparam int SW  = FRAC_BITS + 3;
  localparam int QW  = FRAC_BITS + 4;
  localparam int PQ  = 18 + SW;
  localparam int PT  = QW + 32;
  localparam int STW = PT + 2;
  localparam int TW  = STW - FRAC_BITS;
  localparam int PR  = TW + QW;
  localparam int SRW = PR + 2;
  localparam int RW  = SRW - FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic signed [17:0] az;
  } item_t;

  // arctangent of 2^-i in binary-angle units (2^32 per turn)
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] a;
    unique case (idx)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      5'd30: a = 30'd1;
      5'd31: a = 30'd0;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/quaternion_axis_angle_rotate.sv
// Rotates a Q16.16 vector about an axis by an angle using the quaternion
// q = (axis*sin(a/2), cos(a/2)) and the product q*v*conj(q).
// Input stream: in_tvalid/in_tready/in_tdata carry vector, axis and angle.
// Output stream: out_tdata carries x, y, z in Q16.16; out_tuser flags that
// at least one component was saturated.
// Throughput: one request per cycle while out_tready does not hold the
// output; angle reduction, one register per CORDIC iteration and the two
// product rounds each occupy their own stages.
// Every stage has a valid bit. A stage loads when it is empty or when the
// stage after it moves, so bubbles collapse while the output is stalled
// and in_tready stays high until every stage holds a request.
// When out_tready is low, out_tvalid and out_tdata hold until taken.
// Synchronous reset clears all valid bits; payload registers are not reset.
module quaternion_axis_angle_rotate (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg, 2 zero bits
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z
  output logic [95:0]  out_tdata,
  // overflow
  output logic [0:0]   out_tuser
);

  localparam int CS      = qrot_pkg::CORDIC_STAGES;
  localparam int FB      = qrot_pkg::FRAC_BITS;
  localparam int CW      = qrot_pkg::CW;
  localparam int ST_E    = 4;
  localparam int ST_F    = 5 + CS;
  localparam int ST_G    = 6 + CS;
  localparam int ST_H    = 7 + CS;
  localparam int ST_I    = 8 + CS;
  localparam int ST_J    = 9 + CS;
  localparam int ST_K    = 10 + CS;
  localparam int NST     = 11 + CS;

  logic [NST-1:0] v_r;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = ~v_r[NST-1] | out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = ~v_r[k] | rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NST-1];

  // stage A: unpack, reduce angle into [0, 360) degrees
  qrot_pkg::item_t    in_itm;
  logic signed [16:0] ang_s;
  logic signed [16:0] ang_w;
  logic [14:0]        h_nxt;

  always_comb begin
    in_itm.vx = in_tdata[31:0];
    in_itm.vy = in_tdata[63:32];
    in_itm.vz = in_tdata[95:64];
    in_itm.ax = in_tdata[113:96];
    in_itm.ay = in_tdata[131:114];
    in_itm.az = in_tdata[149:132];
    ang_s = 17'(signed'(in_tdata[165:150]));
    ang_w = ang_s;
    if (ang_s < 0) begin
      ang_w = ang_s + 17'(qrot_pkg::TURN_UNITS);
      if (ang_w < 0) ang_w = ang_w + 17'(qrot_pkg::TURN_UNITS);
    end else if (ang_s >= 17'(qrot_pkg::TURN_UNITS)) begin
      ang_w = ang_s - 17'(qrot_pkg::TURN_UNITS);
    end
    h_nxt = ang_w[14:0];
  end

  qrot_pkg::item_t a_itm_r;
  logic [14:0]     a_h_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_itm_r <= in_itm;
      a_h_r   <= h_nxt;
    end
  end

  // stage B: q = h / 45
  logic [29:0]     b_qm;
  qrot_pkg::item_t b_itm_r;
  logic [14:0]     b_h_r;
  logic [8:0]      b_q_r;

  assign b_qm = 30'(a_h_r) * 30'(qrot_pkg::ANG_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b_itm_r <= a_itm_r;
      b_h_r   <= a_h_r;
      b_q_r   <= b_qm[qrot_pkg::ANG_RSH +: 9];
    end
  end

  // stage C: remainder and fractional numerator
  logic [14:0]     c_rem;
  qrot_pkg::item_t c_itm_r;
  logic [8:0]      c_q_r;
  logic [5:0]      c_r_r;
  logic [10:0]     c_t_r;

  assign c_rem = b_h_r - 15'(15'(b_q_r) * 15'(qrot_pkg::ANG_DIV));

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      c_itm_r <= b_itm_r;
      c_q_r   <= b_q_r;
      c_r_r   <= c_rem[5:0];
      c_t_r   <= 11'(11'(c_rem[5:0]) * 11'(qrot_pkg::FRAC_SCALE))
                 + 11'(qrot_pkg::FRAC_BIAS);
    end
  end

  // stage D: binary angle u
  logic [21:0]     d_fm;
  logic [31:0]     d_u_nxt;
  qrot_pkg::item_t d_itm_r;
  logic [31:0]     d_u_r;

  always_comb begin
    d_fm    = 22'(c_t_r) * 22'(qrot_pkg::RES_RECIP);
    d_u_nxt = {1'b0, c_q_r, 22'd0}
              + 32'(32'(c_r_r) * 32'(qrot_pkg::FRAC_STEP))
              + 32'(d_fm[qrot_pkg::RES_RSH +: 6]);
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      d_itm_r <= c_itm_r;
      d_u_r   <= d_u_nxt;
    end
  end

  // stage E and CORDIC iterations
  qrot_pkg::item_t    k_itm_r [CS+1];
  logic signed [CW-1:0] kx_r  [CS+1];
  logic signed [CW-1:0] ky_r  [CS+1];
  logic signed [CW-1:0] kz_r  [CS+1];
  logic                 kf_r  [CS+1];

  always_ff @(posedge clk) begin
    if (rdy[ST_E]) begin
      k_itm_r[0] <= d_itm_r;
      kx_r[0]    <= CW'(qrot_pkg::CORDIC_GAIN);
      ky_r[0]    <= '0;
      // fold half angles above 90 degrees
      if (d_u_r > 32'h4000_0000) begin
        kz_r[0] <= CW'(d_u_r) - (CW'(1) <<< 31);
        kf_r[0] <= 1'b1;
      end else begin
        kz_r[0] <= CW'(d_u_r);
        kf_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;

    assign xs = kx_r[i] >>> i;
    assign ys = ky_r[i] >>> i;
    assign at = CW'(qrot_pkg::atan_turn(5'(i)));

    always_ff @(posedge clk) begin
      if (rdy[ST_E+1+i]) begin
        k_itm_r[i+1] <= k_itm_r[i];
        kf_r[i+1]    <= kf_r[i];
        if (!kz_r[i][CW-1]) begin
          kx_r[i+1] <= kx_r[i] - ys;
          ky_r[i+1] <= ky_r[i] + xs;
          kz_r[i+1] <= kz_r[i] - at;
        end else begin
          kx_r[i+1] <= kx_r[i] + ys;
          ky_r[i+1] <= ky_r[i] - xs;
          kz_r[i+1] <= kz_r[i] + at;
        end
      end
    end
  end

  // stage F: unfold and round sine and cosine
  logic signed [CW-1:0]          f_x;
  logic signed [CW-1:0]          f_y;
  logic signed [CW-1:0]          f_cw;
  logic signed [CW-1:0]          f_sw;
  qrot_pkg::item_t               f_itm_r;
  logic signed [qrot_pkg::SW-1:0] f_c_r;
  logic signed [qrot_pkg::SW-1:0] f_s_r;

  always_comb begin
    f_x  = kf_r[CS] ? -kx_r[CS] : kx_r[CS];
    f_y  = kf_r[CS] ? -ky_r[CS] : ky_r[CS];
    f_cw = (f_x + CW'(2 ** (qrot_pkg::CRD_SH - 1))) >>> qrot_pkg::CRD_SH;
    f_sw = (f_y + CW'(2 ** (qrot_pkg::CRD_SH - 1))) >>> qrot_pkg::CRD_SH;
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_F]) begin
      f_itm_r <= k_itm_r[CS];
      f_c_r   <= f_cw[qrot_pkg::SW-1:0];
      f_s_r   <= f_sw[qrot_pkg::SW-1:0];
    end
  end

  // stage G: quaternion vector part
  localparam int PQ = qrot_pkg::PQ;
  localparam int QW = qrot_pkg::QW;

  logic signed [PQ-1:0] g_px;
  logic signed [PQ-1:0] g_py;
  logic signed [PQ-1:0] g_pz;
  qrot_pkg::item_t      g_itm_r;
  logic signed [QW-1:0] g_qx_r;
  logic signed [QW-1:0] g_qy_r;
  logic signed [QW-1:0] g_qz_r;
  logic signed [QW-1:0] g_qw_r;

  always_comb begin
    g_px = (PQ'(f_itm_r.ax) * PQ'(f_s_r) + PQ'(2 ** 15)) >>> 16;
    g_py = (PQ'(f_itm_r.ay) * PQ'(f_s_r) + PQ'(2 ** 15)) >>> 16;
    g_pz = (PQ'(f_itm_r.az) * PQ'(f_s_r) + PQ'(2 ** 15)) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_G]) begin
      g_itm_r <= f_itm_r;
      g_qx_r  <= g_px[QW-1:0];
      g_qy_r  <= g_py[QW-1:0];
      g_qz_r  <= g_pz[QW-1:0];
      g_qw_r  <= QW'(f_c_r);
    end
  end

  // stage H: products of q*v
  localparam int PT  = qrot_pkg::PT;
  localparam int STW = qrot_pkg::STW;
  localparam int TW  = qrot_pkg::TW;

  logic signed [PT-1:0] h_p_r [12];
  logic signed [QW-1:0] h_qx_r;
  logic signed [QW-1:0] h_qy_r;
  logic signed [QW-1:0] h_qz_r;
  logic signed [QW-1:0] h_qw_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_H]) begin
      h_p_r[0]  <= PT'(g_qx_r) * PT'(g_itm_r.vx);
      h_p_r[1]  <= PT'(g_qy_r) * PT'(g_itm_r.vy);
      h_p_r[2]  <= PT'(g_qz_r) * PT'(g_itm_r.vz);
      h_p_r[3]  <= PT'(g_qw_r) * PT'(g_itm_r.vx);
      h_p_r[4]  <= PT'(g_qy_r) * PT'(g_itm_r.vz);
      h_p_r[5]  <= PT'(g_qz_r) * PT'(g_itm_r.vy);
      h_p_r[6]  <= PT'(g_qw_r) * PT'(g_itm_r.vy);
      h_p_r[7]  <= PT'(g_qz_r) * PT'(g_itm_r.vx);
      h_p_r[8]  <= PT'(g_qx_r) * PT'(g_itm_r.vz);
      h_p_r[9]  <= PT'(g_qw_r) * PT'(g_itm_r.vz);
      h_p_r[10] <= PT'(g_qx_r) * PT'(g_itm_r.vy);
      h_p_r[11] <= PT'(g_qy_r) * PT'(g_itm_r.vx);
      h_qx_r    <= g_qx_r;
      h_qy_r    <= g_qy_r;
      h_qz_r    <= g_qz_r;
      h_qw_r    <= g_qw_r;
    end
  end

  // stage I: sum and round t = q*v
  localparam logic signed [STW-1:0] T_HALF = STW'(2 ** (FB - 1));

  logic signed [STW-1:0] i_sw;
  logic signed [STW-1:0] i_sx;
  logic signed [STW-1:0] i_sy;
  logic signed [STW-1:0] i_sz;
  logic signed [TW-1:0]  i_tw_r;
  logic signed [TW-1:0]  i_tx_r;
  logic signed [TW-1:0]  i_ty_r;
  logic signed [TW-1:0]  i_tz_r;
  logic signed [QW-1:0]  i_qx_r;
  logic signed [QW-1:0]  i_qy_r;
  logic signed [QW-1:0]  i_qz_r;
  logic signed [QW-1:0]  i_qw_r;

  always_comb begin
    i_sw = (-STW'(h_p_r[0]) - STW'(h_p_r[1]) - STW'(h_p_r[2]) + T_HALF) >>> FB;
    i_sx = (STW'(h_p_r[3]) + STW'(h_p_r[4]) - STW'(h_p_r[5]) + T_HALF) >>> FB;
    i_sy = (STW'(h_p_r[6]) + STW'(h_p_r[7]) - STW'(h_p_r[8]) + T_HALF) >>> FB;
    i_sz = (STW'(h_p_r[9]) + STW'(h_p_r[10]) - STW'(h_p_r[11]) + T_HALF) >>> FB;
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_I]) begin
      i_tw_r <= i_sw[TW-1:0];
      i_tx_r <= i_sx[TW-1:0];
      i_ty_r <= i_sy[TW-1:0];
      i_tz_r <= i_sz[TW-1:0];
      i_qx_r <= h_qx_r;
      i_qy_r <= h_qy_r;
      i_qz_r <= h_qz_r;
      i_qw_r <= h_qw_r;
    end
  end

  // stage J: products of t*conj(q)
  localparam int PR  = qrot_pkg::PR;
  localparam int SRW = qrot_pkg::SRW;
  localparam int RW  = qrot_pkg::RW;

  logic signed [PR-1:0] j_p_r [12];

  always_ff @(posedge clk) begin
    if (rdy[ST_J]) begin
      j_p_r[0]  <= PR'(i_tx_r) * PR'(i_qw_r);
      j_p_r[1]  <= PR'(i_tw_r) * PR'(i_qx_r);
      j_p_r[2]  <= PR'(i_ty_r) * PR'(i_qz_r);
      j_p_r[3]  <= PR'(i_tz_r) * PR'(i_qy_r);
      j_p_r[4]  <= PR'(i_ty_r) * PR'(i_qw_r);
      j_p_r[5]  <= PR'(i_tw_r) * PR'(i_qy_r);
      j_p_r[6]  <= PR'(i_tz_r) * PR'(i_qx_r);
      j_p_r[7]  <= PR'(i_tx_r) * PR'(i_qz_r);
      j_p_r[8]  <= PR'(i_tz_r) * PR'(i_qw_r);
      j_p_r[9]  <= PR'(i_tw_r) * PR'(i_qz_r);
      j_p_r[10] <= PR'(i_tx_r) * PR'(i_qy_r);
      j_p_r[11] <= PR'(i_ty_r) * PR'(i_qx_r);
    end
  end

  // stage K: sum, round, saturate
  localparam logic signed [SRW-1:0] R_HALF = SRW'(2 ** (FB - 1));

  logic signed [SRW-1:0] k_s [3];
  logic [RW-1:0]         k_r [3];
  logic [31:0]           k_o [3];
  logic [2:0]            k_sat;
  logic [95:0]           out_data_r;
  logic                  out_ovf_r;

  always_comb begin
    k_s[0] = (SRW'(j_p_r[0]) - SRW'(j_p_r[1]) - SRW'(j_p_r[2]) + SRW'(j_p_r[3])
              + R_HALF) >>> FB;
    k_s[1] = (SRW'(j_p_r[4]) - SRW'(j_p_r[5]) - SRW'(j_p_r[6]) + SRW'(j_p_r[7])
              + R_HALF) >>> FB;
    k_s[2] = (SRW'(j_p_r[8]) - SRW'(j_p_r[9]) - SRW'(j_p_r[10]) + SRW'(j_p_r[11])
              + R_HALF) >>> FB;
    for (int n = 0; n < 3; n++) begin
      k_r[n]   = k_s[n][RW-1:0];
      k_sat[n] = !((&k_r[n][RW-1:31]) || !(|k_r[n][RW-1:31]));
      if (k_sat[n]) begin
        k_o[n] = k_r[n][RW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        k_o[n] = k_r[n][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_K]) begin
      out_data_r <= {k_o[2], k_o[1], k_o[0]};
      out_ovf_r  <= |k_sat;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_ovf_r;

endmodule

// File: rtl/core/qrot_checker.sv
module qrot_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [95:0]  out_tdata,
  input logic [0:0]   out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // drop all requests on reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a saturated result carries a clamp value in some component
  a_ovf_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[31:0] == 32'h7fff_ffff || out_tdata[31:0] == 32'h8000_0000 ||
       out_tdata[63:32] == 32'h7fff_ffff || out_tdata[63:32] == 32'h8000_0000 ||
       out_tdata[95:64] == 32'h7fff_ffff || out_tdata[95:64] == 32'h8000_0000))
    else $error("overflow flag without clamped component");

endmodule

bind quaternion_axis_angle_rotate qrot_checker u_qrot_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: sim/testbench.sv
module testbench;

  typedef struct {
    logic signed [31:0] vx, vy, vz;
    logic signed [17:0] ax, ay, az;
    logic signed [15:0] ang;
  } rot_req_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        ovf;
  } rot_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic [0:0]   out_tuser;

  rot_req_t pending_reqs[$];
  rot_res_t expected_rots[$];
  int       err_count;
  int       sent_count;
  int       recv_count;
  int       ovf_seen;
  int       idle_pct;
  int       stall_pct;
  bit       hold_send;

  quaternion_axis_angle_rotate dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint atan_val(int i);
    longint tbl[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                        21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                        333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                        1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    return tbl[i];
  endfunction

  function automatic longint clamp32(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic rot_res_t rotate_vec(rot_req_t r);
    rot_res_t res;
    longint vx, vy, vz, ax, ay, az, h, u, z, x, y, xs, ys, c, s;
    longint qx, qy, qz, qw, tw, tx, ty, tz, rx, ry, rz;
    bit flip;
    bit ovf;
    vx = r.vx; vy = r.vy; vz = r.vz;
    ax = r.ax; ay = r.ay; az = r.az;
    h = ((longint'(r.ang) % qrot_pkg::TURN_UNITS) + qrot_pkg::TURN_UNITS)
        % qrot_pkg::TURN_UNITS;
    u = (h * (longint'(1) << 32) + qrot_pkg::TURN_UNITS) / (2 * qrot_pkg::TURN_UNITS);
    flip = 0;
    ovf = 0;
    if (u > (longint'(1) << 30)) begin
      z = u - (longint'(1) << 31);
      flip = 1;
    end else begin
      z = u;
    end
    x = qrot_pkg::CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < qrot_pkg::CORDIC_STAGES && i < 32; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_val(i);
      end else begin
        x += ys; y -= xs; z += atan_val(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = rnd_shift(x, 30 - qrot_pkg::FRAC_BITS);
    s = rnd_shift(y, 30 - qrot_pkg::FRAC_BITS);
    qx = rnd_shift(ax * s, 16);
    qy = rnd_shift(ay * s, 16);
    qz = rnd_shift(az * s, 16);
    qw = c;
    tw = rnd_shift(-(qx * vx) - (qy * vy) - (qz * vz), qrot_pkg::FRAC_BITS);
    tx = rnd_shift((qw * vx) + (qy * vz) - (qz * vy), qrot_pkg::FRAC_BITS);
    ty = rnd_shift((qw * vy) + (qz * vx) - (qx * vz), qrot_pkg::FRAC_BITS);
    tz = rnd_shift((qw * vz) + (qx * vy) - (qy * vx), qrot_pkg::FRAC_BITS);
    rx = rnd_shift(tx * qw - tw * qx - ty * qz + tz * qy, qrot_pkg::FRAC_BITS);
    ry = rnd_shift(ty * qw - tw * qy - tz * qx + tx * qz, qrot_pkg::FRAC_BITS);
    rz = rnd_shift(tz * qw - tw * qz - tx * qy + ty * qx, qrot_pkg::FRAC_BITS);
    res.x = 32'(clamp32(rx, ovf));
    res.y = 32'(clamp32(ry, ovf));
    res.z = 32'(clamp32(rz, ovf));
    res.ovf = ovf;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d, %s: got %h, want %h", recv_count, what, got, want);
    err_count++;
  endtask

  function automatic logic [167:0] pack_req(rot_req_t r);
    return {2'b00, r.ang, r.az, r.ay, r.ax, r.vz, r.vy, r.vx};
  endfunction

  // driver: advance on handshake, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (!hold_send && pending_reqs.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
        rot_req_t r;
        r = pending_reqs.pop_front();
        expected_rots.push_back(rotate_vec(r));
        in_tdata  <= pack_req(r);
        in_tvalid <= 1'b1;
        sent_count++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_rots.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], 32'h0);
        end else begin
          rot_res_t e;
          e = expected_rots.pop_front();
          if (out_tdata[31:0] !== e.x) report_mismatch("x", out_tdata[31:0], e.x);
          if (out_tdata[63:32] !== e.y) report_mismatch("y", out_tdata[63:32], e.y);
          if (out_tdata[95:64] !== e.z) report_mismatch("z", out_tdata[95:64], e.z);
          if (out_tuser[0] !== e.ovf)
            report_mismatch("overflow", 32'(out_tuser), 32'(e.ovf));
          if (e.ovf) ovf_seen++;
        end
        recv_count++;
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic rot_req_t rand_req(int kind);
    rot_req_t r;
    int a;
    r.vx = $urandom; r.vy = $urandom; r.vz = $urandom;
    r.ax = $urandom; r.ay = $urandom; r.az = $urandom;
    r.ang = $urandom;
    if (kind < 6) begin
      // moderate vector, near-unit axis
      r.vx = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
      r.vy = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
      r.vz = $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
      a = $urandom_range(2);
      r.ax = (a == 0) ? 18'sd65536 : $signed(18'($urandom_range(0, 75000))) - 18'sd37500;
      r.ay = (a == 1) ? 18'sd65536 : $signed(18'($urandom_range(0, 75000))) - 18'sd37500;
      r.az = (a == 2) ? -18'sd65536 : $signed(18'($urandom_range(0, 75000))) - 18'sd37500;
    end else if (kind == 6) begin
      r.ang = 16'($urandom_range(0, 11)) * 16'sd1920;
    end
    return r;
  endfunction

  task automatic add_req(logic signed [31:0] vx, vy, vz,
                         logic signed [17:0] ax, ay, az, logic signed [15:0] ang);
    rot_req_t r;
    r.vx = vx; r.vy = vy; r.vz = vz;
    r.ax = ax; r.ay = ay; r.az = az; r.ang = ang;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rots.size() > 0 || in_tvalid)
      @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    err_count = 0; sent_count = 0; recv_count = 0; ovf_seen = 0;
    idle_pct = 0; stall_pct = 0; hold_send = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: key angles, extremes, zero axis, saturation
    add_req(32'sh10000, 0, 0, 0, 0, 18'sd65536, 16'sd5760);
    add_req(32'sh10000, 32'sh20000, 32'sh30000, 18'sd65536, 0, 0, 0);
    add_req(32'sh10000, 0, 0, 0, 0, 18'sd65536, 16'sd11520);
    add_req(32'sh10000, 0, 0, 0, 18'sd65536, 0, 16'sd17280);
    add_req(32'sh10000, 0, 0, 0, 18'sd65536, 0, -16'sd5760);
    add_req(32'sh10000, 32'sh10000, 0, 0, 0, 18'sd65536, 16'sd23040 - 16'sd1);
    add_req(32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0, 16'sd3000);
    add_req(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 18'sd65536, 16'sd2880);
    add_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 18'sd65536, 0, 0, 16'sd2880);
    add_req(32'sh4000_0000, 32'sh1, 32'sh8000_0000,
            18'sh1ffff, 18'sh1ffff, 18'sh1ffff, 16'sh7fff);
    add_req(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0,
            -18'sd131072, -18'sd131072, -18'sd131072, -16'sd32768);
    add_req(32'sh10000, 32'sh10000, 32'sh10000, 18'sd37837, 18'sd37837, 18'sd37837, 16'sd7680);
    add_req(0, 0, 0, 18'sd65536, 18'sd65536, 18'sd65536, 16'sd1234);
    add_req(-32'sh10000, 32'sh5000, 32'sh1, 0, 18'sd65536, 0, 16'sd1);
    add_req(32'sh12345, -32'sh54321, 32'sh777, 0, 0, 18'sd65536, 16'sd11521);
    hold_send = 1'b0;
    drain();

    // hold off until the pipe empties, then random phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 77 : ((ph == 3) ? 27 : 0);
      stall_pct = (ph == 2) ? 77 : ((ph == 3) ? 27 : 0);
      for (int i = 0; i < 475; i++)
        pending_reqs.push_back(rand_req($urandom_range(9)));
      drain();
    end
    idle_pct = 0; stall_pct = 0;
    repeat (40) @(posedge clk);
    $display("covered %0d rotations (%0d saturated) across idle and stall phases",
             recv_count, ovf_seen);
    if (err_count == 0 && expected_rots.size() == 0) begin
      $display("[quaternion_axis_angle_rotate] OK");
    end else begin
      $display("[quaternion_axis_angle_rotate] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout after %0d of %0d results", recv_count, sent_count);
    $display("[quaternion_axis_angle_rotate] ERROR");
    $finish;
  end

endmodule
